/* rtl/led_frame_packetizer_core_assert.svh */
// ---------------------------------------------------------------------------
// led frame packetizer assertion macros
// concurrent checks on a clock with a synchronous reset that disables them
// ---------------------------------------------------------------------------
`ifndef LED_FRAME_PACKETIZER_CORE_ASSERT_SVH
`define LED_FRAME_PACKETIZER_CORE_ASSERT_SVH

// same-cycle implication
`define LFP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lfp_pkg.sv */
// ---------------------------------------------------------------------------
// lfp_pkg
// constants, microcode word layout and microcode program of the packetizer
// ---------------------------------------------------------------------------
package lfp_pkg;

   localparam logic [7:0]  START_BYTE    = 8'h9c;
   localparam logic [7:0]  TYPE_BYTE     = 8'hda;
   localparam logic [7:0]  END_BYTE      = 8'h36;
   localparam logic [15:0] PAYLOAD_RESET = 16'd170;

   typedef logic [15:0] len_type;
   typedef logic [7:0]  count_type;
   typedef logic [4:0]  div_count_type;

   localparam div_count_type DIV_STEPS = 5'd16;

   typedef logic [3:0] step_type;

   localparam step_type STEP_WAIT    = 4'd0;
   localparam step_type STEP_FRAME   = 4'd1;
   localparam step_type STEP_DIV     = 4'd2;
   localparam step_type STEP_PKT     = 4'd3;
   localparam step_type STEP_START   = 4'd4;
   localparam step_type STEP_TYPE    = 4'd5;
   localparam step_type STEP_SIZE_HI = 4'd6;
   localparam step_type STEP_SIZE_LO = 4'd7;
   localparam step_type STEP_NUMBER  = 4'd8;
   localparam step_type STEP_TOTAL   = 4'd9;
   localparam step_type STEP_DATA    = 4'd10;
   localparam step_type STEP_END     = 4'd11;

   typedef enum logic [3:0] {
      EMIT_NONE,
      EMIT_START,
      EMIT_TYPE,
      EMIT_SIZE_HI,
      EMIT_SIZE_LO,
      EMIT_NUMBER,
      EMIT_TOTAL,
      EMIT_DATA,
      EMIT_END
   } emit_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_ACCEPT,
      ACT_FRAME_INIT,
      ACT_LOAD_TOTAL,
      ACT_LOAD_PAYLOAD,
      ACT_NEXT_NUMBER,
      ACT_ADVANCE,
      ACT_CLOSE
   } action_type;

   typedef enum logic [2:0] {
      JMP_NEVER,
      JMP_ALWAYS,
      JMP_DISPATCH,
      JMP_DIV_BUSY,
      JMP_NO_END
   } cond_type;

   typedef enum logic [1:0] {
      LAST_NEVER,
      LAST_ALWAYS,
      LAST_NO_END
   } last_type;

   typedef struct packed {
      emit_type   emit;
      action_type action;
      cond_type   cond;
      step_type   target;
      last_type   last;
   } ucode_type;

   typedef struct packed {
      logic    start;
      len_type dividend;
      len_type divisor;
   } div_req_type;

   typedef struct packed {
      logic      busy;
      count_type quotient;
      logic      rem_nonzero;
   } div_res_type;

   // microcode program, one control word per step
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '{emit: EMIT_NONE, action: ACT_NONE, cond: JMP_ALWAYS,
            target: STEP_WAIT, last: LAST_NEVER};
      case (step)
         STEP_WAIT: begin
            w = '{emit: EMIT_NONE, action: ACT_ACCEPT, cond: JMP_DISPATCH,
                  target: STEP_WAIT, last: LAST_NEVER};
         end
         STEP_FRAME: begin
            w = '{emit: EMIT_NONE, action: ACT_FRAME_INIT, cond: JMP_NEVER,
                  target: STEP_WAIT, last: LAST_NEVER};
         end
         STEP_DIV: begin
            w = '{emit: EMIT_NONE, action: ACT_LOAD_TOTAL, cond: JMP_DIV_BUSY,
                  target: STEP_DIV, last: LAST_NEVER};
         end
         STEP_PKT: begin
            w = '{emit: EMIT_NONE, action: ACT_LOAD_PAYLOAD, cond: JMP_NEVER,
                  target: STEP_WAIT, last: LAST_NEVER};
         end
         STEP_START: begin
            w = '{emit: EMIT_START, action: ACT_NONE, cond: JMP_NEVER,
                  target: STEP_WAIT, last: LAST_NEVER};
         end
         STEP_TYPE: begin
            w = '{emit: EMIT_TYPE, action: ACT_NONE, cond: JMP_NEVER,
                  target: STEP_WAIT, last: LAST_NEVER};
         end
         STEP_SIZE_HI: begin
            w = '{emit: EMIT_SIZE_HI, action: ACT_NONE, cond: JMP_NEVER,
                  target: STEP_WAIT, last: LAST_NEVER};
         end
         STEP_SIZE_LO: begin
            w = '{emit: EMIT_SIZE_LO, action: ACT_NONE, cond: JMP_NEVER,
                  target: STEP_WAIT, last: LAST_NEVER};
         end
         STEP_NUMBER: begin
            w = '{emit: EMIT_NUMBER, action: ACT_NEXT_NUMBER, cond: JMP_NEVER,
                  target: STEP_WAIT, last: LAST_NEVER};
         end
         STEP_TOTAL: begin
            w = '{emit: EMIT_TOTAL, action: ACT_NONE, cond: JMP_NEVER,
                  target: STEP_WAIT, last: LAST_NEVER};
         end
         STEP_DATA: begin
            w = '{emit: EMIT_DATA, action: ACT_ADVANCE, cond: JMP_NO_END,
                  target: STEP_WAIT, last: LAST_NO_END};
         end
         STEP_END: begin
            w = '{emit: EMIT_END, action: ACT_CLOSE, cond: JMP_ALWAYS,
                  target: STEP_WAIT, last: LAST_ALWAYS};
         end
         default: begin
            w = '{emit: EMIT_NONE, action: ACT_NONE, cond: JMP_ALWAYS,
                  target: STEP_WAIT, last: LAST_NEVER};
         end
      endcase
      return w;
   endfunction

endpackage

/* rtl/lfp_div.sv */
// ---------------------------------------------------------------------------
// lfp_div
// restoring divider, one quotient bit per cycle, for the packet count
// ---------------------------------------------------------------------------
module lfp_div (
   input  logic                clock,
   input  logic                reset,
   input  lfp_pkg::div_req_type req,
   output lfp_pkg::div_res_type res
);

   logic                   busy_ff, busy_in;
   lfp_pkg::div_count_type count_ff, count_in;
   lfp_pkg::len_type       rem_ff, rem_in;
   lfp_pkg::len_type       quo_ff, quo_in;
   lfp_pkg::len_type       divisor_ff, divisor_in;

   logic [16:0] shifted;
   logic [17:0] diff;
   logic        fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[15]};
      diff    = {1'b0, shifted} - {2'b00, divisor_ff};
      fits    = !diff[17];

      busy_in    = busy_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;

      if (req.start) begin
         busy_in    = 1'b1;
         count_in   = lfp_pkg::DIV_STEPS;
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so 16 bits hold it
         rem_in   = fits ? diff[15:0] : shifted[15:0];
         quo_in   = {quo_ff[14:0], fits};
         count_in = count_ff - 5'd1;
         busy_in  = (count_ff != 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign res.busy        = busy_ff;
   assign res.quotient    = quo_ff[7:0];
   assign res.rem_nonzero = (rem_ff != 16'd0);

endmodule

/* rtl/led_frame_packetizer_core.sv */
// ---------------------------------------------------------------------------
// led_frame_packetizer_core
// splits a frame of led color bytes into packets with a six-byte header
// and an end byte, driven by a small microcode program
// ---------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_data_byte, req_frame_length
//  rsp      out        rsp_valid/rsp_stall   rsp_out_byte, rsp_packet_end,
//                                            rsp_last_of_run
//  csr      in         csr_write_enable      csr_write_data (max_payload)
//
// a data byte inside a packet takes one step to accept and one to emit
// a packet start adds the payload load step and six header byte steps, the end byte its own step
// a frame start adds the frame init step and the wait on the count division, one quotient bit a cycle
// the sequencer takes one item at a time; req_stall is high outside the wait step
// a stalled rsp holds the sequencer on its current emit step
// reset is synchronous and returns to the wait step with max_payload at 170
// ---------------------------------------------------------------------------
`include "led_frame_packetizer_core_assert.svh"

module led_frame_packetizer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_frame_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_packet_end,
   output logic        rsp_last_of_run,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   lfp_pkg::step_type  step_ff, step_in;
   lfp_pkg::len_type   max_payload_ff, max_payload_in;
   lfp_pkg::len_type   frame_pos_ff, frame_pos_in;
   lfp_pkg::len_type   pkt_pos_ff, pkt_pos_in;
   lfp_pkg::count_type pkt_num_ff, pkt_num_in;
   lfp_pkg::count_type pkt_total_ff, pkt_total_in;
   lfp_pkg::len_type   frame_total_ff, frame_total_in;
   lfp_pkg::len_type   pkt_payload_ff, pkt_payload_in;
   logic [7:0]         data_ff, data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_end_ff, rsp_end_in;
   logic               rsp_last_ff, rsp_last_in;

   lfp_pkg::ucode_type   uc;
   lfp_pkg::div_req_type div_req;
   lfp_pkg::div_res_type div_res;

   lfp_pkg::len_type eff_payload;
   lfp_pkg::len_type pkt_pos_inc;
   lfp_pkg::len_type frame_pos_inc;
   lfp_pkg::len_type bytes_left;
   logic             end_on_inc;
   logic             frame_end_now;
   logic             out_free;
   logic             advance;
   logic             taken;
   lfp_pkg::step_type target;

   lfp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .res   (div_res)
   );

   always_comb begin
      uc = lfp_pkg::ucode_rom(step_ff);

      eff_payload   = (max_payload_ff == 16'd0) ? 16'd1 : max_payload_ff;
      pkt_pos_inc   = pkt_pos_ff + 16'd1;
      frame_pos_inc = frame_pos_ff + 16'd1;
      bytes_left    = frame_total_ff - frame_pos_ff;
      end_on_inc    = (pkt_pos_inc >= pkt_payload_ff) || (frame_pos_inc >= frame_total_ff)
                      || (frame_pos_inc == 16'd0);
      frame_end_now = (frame_pos_ff >= frame_total_ff) || (frame_pos_ff == 16'd0);
      out_free      = !rsp_valid_ff || !rsp_stall;

      // emit steps wait for the output register, the wait step for an item
      if (uc.emit != lfp_pkg::EMIT_NONE) begin
         advance = out_free;
      end else if (uc.cond == lfp_pkg::JMP_DISPATCH) begin
         advance = req_valid;
      end else begin
         advance = 1'b1;
      end

      case (uc.cond)
         lfp_pkg::JMP_NEVER:    taken = 1'b0;
         lfp_pkg::JMP_ALWAYS:   taken = 1'b1;
         lfp_pkg::JMP_DISPATCH: taken = 1'b1;
         lfp_pkg::JMP_DIV_BUSY: taken = div_res.busy;
         lfp_pkg::JMP_NO_END:   taken = !end_on_inc;
         default:               taken = 1'b0;
      endcase

      if (uc.cond == lfp_pkg::JMP_DISPATCH) begin
         if (frame_pos_ff == 16'd0) begin
            target = lfp_pkg::STEP_FRAME;
         end else if (pkt_pos_ff == 16'd0) begin
            target = lfp_pkg::STEP_PKT;
         end else begin
            target = lfp_pkg::STEP_DATA;
         end
      end else begin
         target = uc.target;
      end

      step_in = step_ff;
      if (advance) begin
         step_in = taken ? target : step_ff + 4'd1;
      end

      max_payload_in = csr_write_enable ? csr_write_data : max_payload_ff;

      frame_pos_in   = frame_pos_ff;
      pkt_pos_in     = pkt_pos_ff;
      pkt_num_in     = pkt_num_ff;
      pkt_total_in   = pkt_total_ff;
      frame_total_in = frame_total_ff;
      pkt_payload_in = pkt_payload_ff;
      data_in        = data_ff;

      div_req.start    = 1'b0;
      div_req.dividend = frame_total_ff;
      div_req.divisor  = eff_payload;

      if (advance) begin
         case (uc.action)
            lfp_pkg::ACT_NONE: begin
            end
            lfp_pkg::ACT_ACCEPT: begin
               data_in = req_data_byte;
               if (frame_pos_ff == 16'd0) begin
                  frame_total_in = (req_frame_length == 16'd0) ? 16'd1 : req_frame_length;
               end
            end
            lfp_pkg::ACT_FRAME_INIT: begin
               div_req.start = 1'b1;
               pkt_num_in    = 8'd1;
               pkt_pos_in    = 16'd0;
            end
            lfp_pkg::ACT_LOAD_TOTAL: begin
               // ceiling: round the quotient up on a nonzero remainder
               if (!div_res.busy) begin
                  pkt_total_in = div_res.quotient + {7'd0, div_res.rem_nonzero};
               end
            end
            lfp_pkg::ACT_LOAD_PAYLOAD: begin
               pkt_payload_in = (bytes_left < eff_payload) ? bytes_left : eff_payload;
            end
            lfp_pkg::ACT_NEXT_NUMBER: begin
               pkt_num_in = pkt_num_ff + 8'd1;
            end
            lfp_pkg::ACT_ADVANCE: begin
               pkt_pos_in   = pkt_pos_inc;
               frame_pos_in = frame_pos_inc;
            end
            lfp_pkg::ACT_CLOSE: begin
               pkt_pos_in = 16'd0;
               if (frame_end_now) begin
                  frame_pos_in = 16'd0;
                  pkt_num_in   = 8'd1;
               end
            end
            default: begin
            end
         endcase
      end

      case (uc.emit)
         lfp_pkg::EMIT_START:   rsp_byte_in = lfp_pkg::START_BYTE;
         lfp_pkg::EMIT_TYPE:    rsp_byte_in = lfp_pkg::TYPE_BYTE;
         lfp_pkg::EMIT_SIZE_HI: rsp_byte_in = pkt_payload_ff[15:8];
         lfp_pkg::EMIT_SIZE_LO: rsp_byte_in = pkt_payload_ff[7:0];
         lfp_pkg::EMIT_NUMBER:  rsp_byte_in = pkt_num_ff;
         lfp_pkg::EMIT_TOTAL:   rsp_byte_in = pkt_total_ff;
         lfp_pkg::EMIT_DATA:    rsp_byte_in = data_ff;
         lfp_pkg::EMIT_END:     rsp_byte_in = lfp_pkg::END_BYTE;
         default:               rsp_byte_in = rsp_byte_ff;
      endcase

      case (uc.last)
         lfp_pkg::LAST_NEVER:  rsp_last_in = 1'b0;
         lfp_pkg::LAST_ALWAYS: rsp_last_in = 1'b1;
         lfp_pkg::LAST_NO_END: rsp_last_in = !end_on_inc;
         default:              rsp_last_in = 1'b0;
      endcase

      rsp_end_in   = (uc.emit == lfp_pkg::EMIT_END);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if ((uc.emit != lfp_pkg::EMIT_NONE) && out_free) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_byte_in = rsp_byte_ff;
         rsp_end_in  = rsp_end_ff;
         rsp_last_in = rsp_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= lfp_pkg::STEP_WAIT;
         max_payload_ff <= lfp_pkg::PAYLOAD_RESET;
         frame_pos_ff   <= '0;
         pkt_pos_ff     <= '0;
         pkt_num_ff     <= 8'd1;
         pkt_total_ff   <= '0;
         frame_total_ff <= '0;
         pkt_payload_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         step_ff        <= step_in;
         max_payload_ff <= max_payload_in;
         frame_pos_ff   <= frame_pos_in;
         pkt_pos_ff     <= pkt_pos_in;
         pkt_num_ff     <= pkt_num_in;
         pkt_total_ff   <= pkt_total_in;
         frame_total_ff <= frame_total_in;
         pkt_payload_ff <= pkt_payload_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      data_ff     <= data_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall       = (step_ff != lfp_pkg::STEP_WAIT);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_packet_end  = rsp_end_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // end byte always closes the run of its item
   `LFP_ASSERT_IMPLY(a_end_is_last, clock, reset, rsp_valid_ff && rsp_end_ff, rsp_last_ff, "end byte without last flag")

   // the divider only runs while the sequencer waits on it
   `LFP_ASSERT_IMPLY(a_div_in_step, clock, reset, div_res.busy, step_ff == lfp_pkg::STEP_DIV, "divider busy outside its step")

   // a data byte that fills the packet or ends the frame is followed by the end byte
   `LFP_ASSERT_NEXT(a_data_then_end, clock, reset, (step_ff == lfp_pkg::STEP_DATA) && out_free && end_on_inc, step_ff == lfp_pkg::STEP_END, "missing end byte after packet fill")

   // between items the packet position stays inside the packet
   `LFP_ASSERT_IMPLY(a_pos_in_packet, clock, reset, step_ff == lfp_pkg::STEP_WAIT, (pkt_pos_ff == 16'd0) || (pkt_pos_ff < pkt_payload_ff), "packet position past payload")

endmodule

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// packetizer check: color bytes go in, the header, data and end byte stream
// is predicted per accepted item and compared byte by byte as it comes out
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 6;
   localparam int RANDOM_ITEMS = 20;
   localparam int SEND_IDLE[4]  = '{0, 84, 0, 11};
   localparam int RECV_STALL[4] = '{0, 0, 84, 11};

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] frame_length;
   } color_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
      logic       last_of_run;
   } stream_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic [15:0] req_frame_length = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_packet_end;
   logic        rsp_last_of_run;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = 16'h0000;

   color_item_type  bytes_to_send[$];
   stream_byte_type stream_due[$];
   color_item_type  next_item;
   stream_byte_type due_byte;
   stream_byte_type seen_byte;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   logic hold_start = 1'b0;

   // packetizer state as seen from outside
   logic [15:0] payload_cfg = lfp_pkg::PAYLOAD_RESET;
   logic [15:0] frame_pos = '0;
   logic [15:0] pkt_pos = '0;
   logic [7:0]  pkt_num = 8'd1;
   logic [7:0]  pkt_total = '0;
   logic [15:0] frame_tot = '0;
   logic [15:0] pkt_pay = '0;

   led_frame_packetizer_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_frame_length (req_frame_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bytes that one color item turns into, appended to stream_due
   function automatic void packetize(input color_item_type item);
      stream_byte_type run[$];
      int unsigned p;
      int unsigned n;
      int unsigned left;
      p = (payload_cfg == 16'd0) ? 1 : payload_cfg;
      if (frame_pos == 16'd0) begin
         n = (item.frame_length == 16'd0) ? 1 : item.frame_length;
         frame_tot = 16'(n);
         pkt_total = 8'((n + p - 1) / p);
         pkt_num = 8'd1;
         pkt_pos = 16'd0;
      end
      if (pkt_pos == 16'd0) begin
         left = frame_tot - frame_pos;
         pkt_pay = 16'((left < p) ? left : p);
         run.push_back('{lfp_pkg::START_BYTE, 1'b0, 1'b0});
         run.push_back('{lfp_pkg::TYPE_BYTE, 1'b0, 1'b0});
         run.push_back('{pkt_pay[15:8], 1'b0, 1'b0});
         run.push_back('{pkt_pay[7:0], 1'b0, 1'b0});
         run.push_back('{pkt_num, 1'b0, 1'b0});
         run.push_back('{pkt_total, 1'b0, 1'b0});
         pkt_num = pkt_num + 8'd1;
      end
      run.push_back('{item.data_byte, 1'b0, 1'b0});
      pkt_pos = pkt_pos + 16'd1;
      frame_pos = frame_pos + 16'd1;
      if (pkt_pos >= pkt_pay || frame_pos >= frame_tot || frame_pos == 16'd0) begin
         run.push_back('{lfp_pkg::END_BYTE, 1'b1, 1'b0});
         pkt_pos = 16'd0;
      end
      if (frame_pos >= frame_tot || frame_pos == 16'd0) begin
         frame_pos = 16'd0;
         pkt_pos = 16'd0;
         pkt_num = 8'd1;
      end
      run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i]) stream_due.push_back(run[i]);
   endfunction

   task automatic note_mismatch(input string what, input stream_byte_type want,
                                input stream_byte_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected byte %02h end %0b last %0b, got byte %02h end %0b last %0b",
                  $realtime, what, want.out_byte, want.packet_end, want.last_of_run,
                  got.out_byte, got.packet_end, got.last_of_run);
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            packetize('{req_data_byte, req_frame_length});
         end
         if (!req_valid || !req_stall) begin
            if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = bytes_to_send.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_item.data_byte;
               req_frame_length <= next_item.frame_length;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_byte = '{rsp_out_byte, rsp_packet_end, rsp_last_of_run};
            if (stream_due.size() == 0) begin
               note_mismatch("byte with nothing pending", '0, seen_byte);
            end else begin
               due_byte = stream_due.pop_front();
               if (seen_byte !== due_byte) begin
                  note_mismatch("wrong byte", due_byte, seen_byte);
               end
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic queue_bytes(input int unsigned count);
      repeat (count) bytes_to_send.push_back('{8'($urandom), 16'($urandom)});
   endtask

   task automatic queue_frame(input int unsigned len);
      bytes_to_send.push_back('{8'($urandom), 16'(len)});
      queue_bytes((len == 0) ? 0 : len - 1);
   endtask

   task automatic wait_drained;
      do @(negedge clock);
      while (bytes_to_send.size() != 0 || req_valid || stream_due.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_payload(input logic [15:0] value);
      wait_drained();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      payload_cfg = value;
   endtask

   initial begin
      logic [15:0] phase_payload[8];
      int unsigned n;
      int unsigned eff_p;
      int queued;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset payload: two-byte frame with data extremes, zero length, one byte
      bytes_to_send.push_back('{8'h00, 16'd2});
      bytes_to_send.push_back('{8'hff, 16'hffff});
      queue_frame(0);
      queue_frame(1);

      // zero payload behaves as one byte per packet
      write_payload(16'd0);
      queue_frame(3);

      // exact multiple, then a payload change in the middle of a frame
      write_payload(16'd4);
      queue_frame(8);
      bytes_to_send.push_back('{8'($urandom), 16'd10});
      queue_bytes(4);
      write_payload(16'd2);
      queue_bytes(5);

      // packet number and count wrap past 255
      write_payload(16'd1);
      queue_frame(257);

      phase_payload = '{16'd5, 16'd1, 16'd3, 16'd0, 16'($urandom_range(6, 40)),
                        lfp_pkg::PAYLOAD_RESET, 16'd2, 16'hffff};
      for (int ph = 0; ph < 8; ph++) begin
         write_payload(phase_payload[ph]);
         send_idle_pct = SEND_IDLE[ph % 4];
         recv_stall_pct = RECV_STALL[ph % 4];
         eff_p = (phase_payload[ph] == 16'd0) ? 1 : phase_payload[ph];
         if (ph == 0) begin
            @(posedge clock);
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         queued = 0;
         while (queued < RANDOM_ITEMS) begin
            case ($urandom_range(9))
               0: n = 0;
               1: n = $urandom_range(25, 64);
               2: begin
                  n = eff_p * $urandom_range(1, 3);
                  if (n > 64) n = $urandom_range(1, 24);
               end
               default: n = $urandom_range(1, 24);
            endcase
            queue_frame(n);
            queued += (n == 0) ? 1 : n;
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      foreach (stream_due[i]) note_mismatch("byte never came", stream_due[i], '0);
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/lfp_pkg.sv
rtl/lfp_div.sv
rtl/led_frame_packetizer_core.sv
tb/tb_top.sv
